/* rtl/pcfs_pkg.sv */
// ----------------------------------------------------------------------------
// Frame statistics package
// Shared types, opcodes and constants for the per-channel frame statistics
// block.
// ----------------------------------------------------------------------------
package pcfs_pkg;

  // Default number of channel records
  localparam int unsigned CHANNEL_COUNT_DEF = 16;

  // Cleared value of every minimum field
  localparam logic [31:0] MIN_CLEAR32 = 32'h0000_0FFF;
  localparam logic [15:0] MIN_CLEAR16 = 16'h0FFF;

  // Operation codes on the input channel
  typedef enum logic [1:0] {
    OP_UPDATE       = 2'd0,
    OP_READ         = 2'd1,
    OP_CLEAR_ALL    = 2'd2,
    OP_CLEAR_GLOBAL = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_LAT,
    S_BYTES,
    S_FRAMES,
    S_KEY,
    S_LMAX,
    S_LMIN,
    S_WMAX,
    S_WMIN,
    S_HMAX,
    S_HMIN,
    S_GLOB,
    S_FINISH
  } state_e;

  // One channel record as stored in the record memory
  typedef struct packed {
    logic [31:0] bytes;
    logic [31:0] frames;
    logic [31:0] keys;
    logic [31:0] lat_max;
    logic [31:0] lat_min;
    logic [15:0] wid_max;
    logic [15:0] wid_min;
    logic [15:0] hgt_max;
    logic [15:0] hgt_min;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  // Record contents after a clear
  localparam rec_t REC_CLEAR = '{
    bytes:   32'd0,
    frames:  32'd0,
    keys:    32'd0,
    lat_max: 32'd0,
    lat_min: MIN_CLEAR32,
    wid_max: 16'd0,
    wid_min: MIN_CLEAR16,
    hgt_max: 16'd0,
    hgt_min: MIN_CLEAR16
  };

endpackage

/* rtl/pcfs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pcfs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/per_channel_frame_statistics.sv */
// ----------------------------------------------------------------------------
// Per-channel frame statistics
// Keeps byte, frame and key-frame counts and latency/width/height min and max
// per channel, plus a global frame count. One shared 32-bit add/subtract unit
// performs every sum and compare under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  input    | in_valid_i  / in_ready_o   | op_i, channel_i, data_size_i, ...
//  result   | res_valid_o / res_ready_i  | out_valid_o, bytes_sum_o, ...
//
//  Update of an in-range channel: record memory read, 11 steps of the shared
//  add/compare unit, then writeback, before the input is ready again.
//  Read of an in-range channel: record memory read, then result. Other ops and
//  out-of-range channels go straight to the final step.
//  Reset clears all live bits at once; no clearing pass. A record whose live
//  bit is low reads as the cleared record.
//  A held result does not block the next transfer in; only the final step
//  waits until the result register is free.
//
module per_channel_frame_statistics #(
  parameter int unsigned CHANNEL_COUNT = pcfs_pkg::CHANNEL_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  channel_i,
  input  logic [31:0] data_size_i,
  input  logic        key_frame_i,
  input  logic [31:0] capture_time_i,
  input  logic [31:0] encode_time_i,
  input  logic [15:0] frame_width_i,
  input  logic [15:0] frame_height_i,
  // result channel
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        out_valid_o,
  output logic [31:0] bytes_sum_o,
  output logic [31:0] frames_sum_o,
  output logic [31:0] key_frames_sum_o,
  output logic [31:0] latency_high_o,
  output logic [31:0] latency_low_o,
  output logic [15:0] width_high_o,
  output logic [15:0] width_low_o,
  output logic [15:0] height_high_o,
  output logic [15:0] height_low_o,
  output logic [31:0] encoded_frames_sum_o
);

  import pcfs_pkg::*;

  localparam int unsigned AddrW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  // Control state
  state_e                   state_q, state_d;
  logic [CHANNEL_COUNT-1:0] live_q, live_d;
  logic [31:0]              glob_q, glob_d;
  logic                     res_valid_q, res_valid_d;

  // Working registers
  rec_t        rec_q, rec_d;
  logic [31:0] lat_q, lat_d;
  logic        rec_ok_q, rec_ok_d;

  // Captured input payload
  op_e              op_q;
  logic [AddrW-1:0] idx_q;
  logic [31:0]      size_q;
  logic             key_q;
  logic [31:0]      cap_q;
  logic [31:0]      enc_q;
  logic [15:0]      wid_q;
  logic [15:0]      hgt_q;

  // Result register
  logic        res_ok_q;
  rec_t        res_rec_q;
  logic [31:0] res_glob_q;

  // Memory and shared unit
  logic        ram_re, ram_we, out_load;
  rec_t        ram_rdata;
  logic [31:0] alu_a, alu_b;
  logic        alu_sub;
  logic [32:0] alu_sum;
  logic        alu_lt;

  logic in_xfer;
  logic ch_ok;
  logic op_hit;
  op_e  op_in;

  assign op_in      = op_e'(op_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign ch_ok      = ({1'b0, channel_i} < 9'(CHANNEL_COUNT));
  assign op_hit     = (op_in == OP_UPDATE) || (op_in == OP_READ);

  // Shared add/subtract unit; for a subtract, no carry means a < b
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 33'(alu_sub);
  assign alu_lt  = ~alu_sum[32];

  // Record memory
  pcfs_ram #(
    .Width (REC_W),
    .Depth (CHANNEL_COUNT)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (rec_q),
    .re_i    (ram_re),
    .raddr_i (channel_i[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer: next state, unit operands and working register updates
  always_comb begin
    state_d  = state_q;
    live_d   = live_q;
    glob_d   = glob_q;
    rec_d    = rec_q;
    lat_d    = lat_q;
    rec_ok_d = rec_ok_q;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    alu_a    = 32'd0;
    alu_b    = 32'd0;
    alu_sub  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ram_re   = op_hit && ch_ok;
          rec_ok_d = op_hit && ch_ok;
          if (op_in == OP_CLEAR_ALL) begin
            live_d = '0;
          end
          if (op_in == OP_CLEAR_GLOBAL) begin
            glob_d = 32'd0;
          end
          state_d = (op_hit && ch_ok) ? S_LOAD : S_FINISH;
        end
      end
      S_LOAD: begin
        rec_d   = live_q[idx_q] ? ram_rdata : REC_CLEAR;
        state_d = (op_q == OP_READ) ? S_FINISH : S_LAT;
      end
      S_LAT: begin
        alu_a   = enc_q;
        alu_b   = cap_q;
        alu_sub = 1'b1;
        lat_d   = alu_sum[31:0];
        state_d = S_BYTES;
      end
      S_BYTES: begin
        alu_a       = rec_q.bytes;
        alu_b       = size_q;
        rec_d.bytes = alu_sum[31:0];
        state_d     = S_FRAMES;
      end
      S_FRAMES: begin
        alu_a        = rec_q.frames;
        alu_b        = 32'd1;
        rec_d.frames = alu_sum[31:0];
        state_d      = S_KEY;
      end
      S_KEY: begin
        alu_a      = rec_q.keys;
        alu_b      = {31'd0, key_q};
        rec_d.keys = alu_sum[31:0];
        state_d    = S_LMAX;
      end
      S_LMAX: begin
        alu_a   = rec_q.lat_max;
        alu_b   = lat_q;
        alu_sub = 1'b1;
        if (alu_lt) begin
          rec_d.lat_max = lat_q;
        end
        state_d = S_LMIN;
      end
      S_LMIN: begin
        alu_a   = lat_q;
        alu_b   = rec_q.lat_min;
        alu_sub = 1'b1;
        if (alu_lt) begin
          rec_d.lat_min = lat_q;
        end
        state_d = S_WMAX;
      end
      S_WMAX: begin
        alu_a   = {16'd0, rec_q.wid_max};
        alu_b   = {16'd0, wid_q};
        alu_sub = 1'b1;
        if (alu_lt) begin
          rec_d.wid_max = wid_q;
        end
        state_d = S_WMIN;
      end
      S_WMIN: begin
        alu_a   = {16'd0, wid_q};
        alu_b   = {16'd0, rec_q.wid_min};
        alu_sub = 1'b1;
        if (alu_lt) begin
          rec_d.wid_min = wid_q;
        end
        state_d = S_HMAX;
      end
      S_HMAX: begin
        alu_a   = {16'd0, rec_q.hgt_max};
        alu_b   = {16'd0, hgt_q};
        alu_sub = 1'b1;
        if (alu_lt) begin
          rec_d.hgt_max = hgt_q;
        end
        state_d = S_HMIN;
      end
      S_HMIN: begin
        alu_a   = {16'd0, hgt_q};
        alu_b   = {16'd0, rec_q.hgt_min};
        alu_sub = 1'b1;
        if (alu_lt) begin
          rec_d.hgt_min = hgt_q;
        end
        state_d = S_GLOB;
      end
      S_GLOB: begin
        alu_a   = glob_q;
        alu_b   = 32'd1;
        glob_d  = alu_sum[31:0];
        state_d = S_FINISH;
      end
      S_FINISH: begin
        // write back and hand off once the result register is free
        if (!res_valid_q || res_ready_i) begin
          out_load = 1'b1;
          ram_we   = (op_q == OP_UPDATE) && rec_ok_q;
          if ((op_q == OP_UPDATE) && rec_ok_q) begin
            live_d[idx_q] = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid: set on load, dropped after transfer
  always_comb begin
    res_valid_d = res_valid_q;
    if (out_load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      glob_q      <= 32'd0;
      res_valid_q <= 1'b0;
      rec_ok_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      glob_q      <= glob_d;
      res_valid_q <= res_valid_d;
      rec_ok_q    <= rec_ok_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    lat_q <= lat_d;
    if (in_xfer) begin
      op_q   <= op_in;
      idx_q  <= channel_i[AddrW-1:0];
      size_q <= data_size_i;
      key_q  <= key_frame_i;
      cap_q  <= capture_time_i;
      enc_q  <= encode_time_i;
      wid_q  <= frame_width_i;
      hgt_q  <= frame_height_i;
    end
    if (out_load) begin
      res_ok_q   <= rec_ok_q;
      res_rec_q  <= rec_ok_q ? rec_q : '0;
      res_glob_q <= glob_q;
    end
  end

  // Result ports
  assign res_valid_o          = res_valid_q;
  assign out_valid_o          = res_ok_q;
  assign bytes_sum_o          = res_rec_q.bytes;
  assign frames_sum_o         = res_rec_q.frames;
  assign key_frames_sum_o     = res_rec_q.keys;
  assign latency_high_o       = res_rec_q.lat_max;
  assign latency_low_o        = res_rec_q.lat_min;
  assign width_high_o         = res_rec_q.wid_max;
  assign width_low_o          = res_rec_q.wid_min;
  assign height_high_o        = res_rec_q.hgt_max;
  assign height_low_o         = res_rec_q.hgt_min;
  assign encoded_frames_sum_o = res_glob_q;

  // Assertions
  a_we_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FINISH) && (op_q == OP_UPDATE) && rec_ok_q)
    else $error("record write outside an in-range update");

  a_res_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !out_load |=> !res_valid_o)
    else $error("result valid held after transfer");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (op_in == OP_CLEAR_ALL) |=> (live_q == '0))
    else $error("live bits not cleared");

  a_clear_glob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (op_in == OP_CLEAR_GLOBAL) |=> (glob_q == 32'd0))
    else $error("global count not cleared");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !res_valid_q || res_ready_i)
    else $error("result overwritten before transfer");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-channel frame statistics testbench
// Drives the block through directed corner cases and random traffic under
// sender and receiver stalls. It predicts every result from its own copy of
// the channel records and compares each received result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pcfs_pkg::*;

  localparam int NUM_CH          = CHANNEL_COUNT_DEF;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int STALL_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT  = 2000;

  // One update/read/clear request as offered on the input side
  typedef struct packed {
    op_e         op;
    logic [7:0]  channel;
    logic [31:0] data_size;
    logic        key_frame;
    logic [31:0] capture_time;
    logic [31:0] encode_time;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } frame_item_t;

  // One reported statistics record
  typedef struct packed {
    logic        out_valid;
    logic [31:0] bytes_sum;
    logic [31:0] frames_sum;
    logic [31:0] key_frames_sum;
    logic [31:0] latency_high;
    logic [31:0] latency_low;
    logic [15:0] width_high;
    logic [15:0] width_low;
    logic [15:0] height_high;
    logic [15:0] height_low;
    logic [31:0] encoded_frames_sum;
  } frame_stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready_o;
  frame_item_t offer = '0;
  logic        res_valid_o;
  logic        res_ready = 1'b0;
  frame_stats_t got;

  // Shadow copy of the channel records
  logic [31:0] byte_acc   [NUM_CH];
  logic [31:0] frame_acc  [NUM_CH];
  logic [31:0] key_acc    [NUM_CH];
  logic [31:0] lat_hi     [NUM_CH];
  logic [31:0] lat_lo     [NUM_CH];
  logic [15:0] wid_hi     [NUM_CH];
  logic [15:0] wid_lo     [NUM_CH];
  logic [15:0] hgt_hi     [NUM_CH];
  logic [15:0] hgt_lo     [NUM_CH];
  bit          rec_live   [NUM_CH];
  logic [31:0] global_frames;

  frame_item_t  pending_items[$];
  frame_stats_t expected_stats[$];

  int errors = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int results_seen;
  int stall_left;
  bit stall_done;
  int quiet_cycles;

  per_channel_frame_statistics #(
    .CHANNEL_COUNT(NUM_CH)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .op_i                (offer.op),
    .channel_i           (offer.channel),
    .data_size_i         (offer.data_size),
    .key_frame_i         (offer.key_frame),
    .capture_time_i      (offer.capture_time),
    .encode_time_i       (offer.encode_time),
    .frame_width_i       (offer.frame_width),
    .frame_height_i      (offer.frame_height),
    .res_valid_o         (res_valid_o),
    .res_ready_i         (res_ready),
    .out_valid_o         (got.out_valid),
    .bytes_sum_o         (got.bytes_sum),
    .frames_sum_o        (got.frames_sum),
    .key_frames_sum_o    (got.key_frames_sum),
    .latency_high_o      (got.latency_high),
    .latency_low_o       (got.latency_low),
    .width_high_o        (got.width_high),
    .width_low_o         (got.width_low),
    .height_high_o       (got.height_high),
    .height_low_o        (got.height_low),
    .encoded_frames_sum_o(got.encoded_frames_sum)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the shadow records and return the record it reports
  function automatic frame_stats_t predict_stats(frame_item_t it);
    frame_stats_t r;
    logic [31:0]  lat;
    int           c;
    r   = '0;
    c   = it.channel;
    lat = it.encode_time - it.capture_time;
    case (it.op)
      OP_UPDATE, OP_READ: begin
        if (it.channel < NUM_CH) begin
          // first touch after a clear starts from the cleared record
          if (!rec_live[c]) begin
            byte_acc[c]  = '0;
            frame_acc[c] = '0;
            key_acc[c]   = '0;
            lat_hi[c]    = '0;
            lat_lo[c]    = MIN_CLEAR32;
            wid_hi[c]    = '0;
            wid_lo[c]    = MIN_CLEAR16;
            hgt_hi[c]    = '0;
            hgt_lo[c]    = MIN_CLEAR16;
            rec_live[c]  = 1'b1;
          end
          if (it.op == OP_UPDATE) begin
            byte_acc[c]   = byte_acc[c] + it.data_size;
            frame_acc[c]  = frame_acc[c] + 32'd1;
            global_frames = global_frames + 32'd1;
            if (it.key_frame) key_acc[c] = key_acc[c] + 32'd1;
            if (lat > lat_hi[c]) lat_hi[c] = lat;
            if (lat < lat_lo[c]) lat_lo[c] = lat;
            if (it.frame_width > wid_hi[c]) wid_hi[c] = it.frame_width;
            if (it.frame_width < wid_lo[c]) wid_lo[c] = it.frame_width;
            if (it.frame_height > hgt_hi[c]) hgt_hi[c] = it.frame_height;
            if (it.frame_height < hgt_lo[c]) hgt_lo[c] = it.frame_height;
          end
          r.out_valid      = 1'b1;
          r.bytes_sum      = byte_acc[c];
          r.frames_sum     = frame_acc[c];
          r.key_frames_sum = key_acc[c];
          r.latency_high   = lat_hi[c];
          r.latency_low    = lat_lo[c];
          r.width_high     = wid_hi[c];
          r.width_low      = wid_lo[c];
          r.height_high    = hgt_hi[c];
          r.height_low     = hgt_lo[c];
        end
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < NUM_CH; i++) rec_live[i] = 1'b0;
      end
      OP_CLEAR_GLOBAL: begin
        global_frames = '0;
      end
      default: begin
      end
    endcase
    r.encoded_frames_sum = global_frames;
    return r;
  endfunction

  function automatic frame_item_t make_item(op_e op, logic [7:0] ch, logic [31:0] size,
                                            logic key, logic [31:0] cap, logic [31:0] enc,
                                            logic [15:0] w, logic [15:0] h);
    frame_item_t it;
    it.op           = op;
    it.channel      = ch;
    it.data_size    = size;
    it.key_frame    = key;
    it.capture_time = cap;
    it.encode_time  = enc;
    it.frame_width  = w;
    it.frame_height = h;
    return it;
  endfunction

  // Mostly updates on live channels, some reads, rare clears, a few stray channels
  function automatic frame_item_t random_frame_item();
    frame_item_t it;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 66)      it.op = OP_UPDATE;
    else if (pick < 92) it.op = OP_READ;
    else if (pick < 96) it.op = OP_CLEAR_ALL;
    else                it.op = OP_CLEAR_GLOBAL;
    it.channel   = ($urandom_range(99) < 90) ? 8'($urandom_range(NUM_CH - 1))
                                             : 8'($urandom_range(255));
    it.data_size = ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(65535));
    it.key_frame = 1'($urandom_range(1));
    it.capture_time = $urandom;
    // small latencies straddle the cleared minimum
    it.encode_time  = ($urandom_range(99) < 70) ? it.capture_time + $urandom_range(8000)
                                                : 32'($urandom);
    it.frame_width  = ($urandom_range(99) < 60) ? 16'($urandom_range(8191))
                                                : 16'($urandom_range(65535));
    it.frame_height = ($urandom_range(99) < 60) ? 16'($urandom_range(8191))
                                                : 16'($urandom_range(65535));
    return it;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      errors++;
    end
  endfunction

  // Driver: offer queued requests, predict each one on its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_stats.push_back(predict_stats(offer));
      end
      if (!in_valid || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offer    <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, drive result ready with one long stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready    <= 1'b0;
      results_seen = 0;
      stall_left   = 0;
      stall_done   = 1'b0;
    end else begin
      if (res_valid_o && res_ready) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          frame_stats_t want;
          want = expected_stats.pop_front();
          compare_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
          compare_field("bytes_sum", want.bytes_sum, got.bytes_sum);
          compare_field("frames_sum", want.frames_sum, got.frames_sum);
          compare_field("key_frames_sum", want.key_frames_sum, got.key_frames_sum);
          compare_field("latency_high", want.latency_high, got.latency_high);
          compare_field("latency_low", want.latency_low, got.latency_low);
          compare_field("width_high", 32'(want.width_high), 32'(got.width_high));
          compare_field("width_low", 32'(want.width_low), 32'(got.width_low));
          compare_field("height_high", 32'(want.height_high), 32'(got.height_high));
          compare_field("height_low", 32'(want.height_low), 32'(got.height_low));
          compare_field("encoded_frames_sum", want.encoded_frames_sum,
                        got.encoded_frames_sum);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (!stall_done && results_seen >= 300) begin
        // back-pressure long enough to fill the block and stall its input
        stall_done = 1'b1;
        stall_left = STALL_CYCLES;
        res_ready  <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog: no transfer on either side for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready_o) || (res_valid_o && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequencing
  initial begin
    frame_item_t it;
    int          counted;
    for (int i = 0; i < NUM_CH; i++) rec_live[i] = 1'b0;
    global_frames = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      sender_idle_pct   = (phase == 0) ? 15 : (phase == 1) ? 59 : 0;
      receiver_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 15 : 0;
      if (phase == 0) begin
        // read of a record that was never touched
        pending_items.push_back(make_item(OP_READ, 8'd0, '0, 1'b0, '0, '0, '0, '0));
        // all-zero update pulls every minimum to zero
        pending_items.push_back(make_item(OP_UPDATE, 8'd0, '0, 1'b0, '0, '0, '0, '0));
        // all-ones values stay above the cleared minimum
        pending_items.push_back(make_item(OP_UPDATE, 8'd1, '1, 1'b1, '0, '1,
                                          16'hFFFF, 16'hFFFF));
        // byte total wraps, latency wraps past zero
        pending_items.push_back(make_item(OP_UPDATE, 8'd1, '1, 1'b0, '1, 32'd0,
                                          16'h0FFF, 16'h1000));
        pending_items.push_back(make_item(OP_UPDATE, 8'd1, 32'd100, 1'b1, 32'd10, 32'd20,
                                          16'h0FFE, 16'h0FFF));
        pending_items.push_back(make_item(OP_UPDATE, 8'(NUM_CH - 1), 32'd7, 1'b1,
                                          32'd5, 32'd3, 16'd1920, 16'd1080));
        // stray channels on update and read
        pending_items.push_back(make_item(OP_UPDATE, 8'(NUM_CH), '1, 1'b1, '0, '1,
                                          '1, '1));
        pending_items.push_back(make_item(OP_UPDATE, 8'hFF, '1, 1'b1, '1, '0, '1, '1));
        pending_items.push_back(make_item(OP_READ, 8'(NUM_CH), '0, 1'b0, '0, '0, '0, '0));
        pending_items.push_back(make_item(OP_READ, 8'hFF, '1, 1'b1, '1, '1, '1, '1));
        pending_items.push_back(make_item(OP_READ, 8'd1, '0, 1'b0, '0, '0, '0, '0));
        // global clear keeps the records
        pending_items.push_back(make_item(OP_CLEAR_GLOBAL, 8'd0, '0, 1'b0, '0, '0,
                                          '0, '0));
        pending_items.push_back(make_item(OP_READ, 8'd1, '0, 1'b0, '0, '0, '0, '0));
        // record clear keeps the global count
        pending_items.push_back(make_item(OP_UPDATE, 8'd2, 32'd500, 1'b0, 32'd0,
                                          32'd40, 16'd640, 16'd480));
        pending_items.push_back(make_item(OP_CLEAR_ALL, 8'd1, '1, 1'b1, '1, '1, '1, '1));
        pending_items.push_back(make_item(OP_READ, 8'd1, '0, 1'b0, '0, '0, '0, '0));
        pending_items.push_back(make_item(OP_UPDATE, 8'd1, 32'd1234, 1'b1, 32'd1000,
                                          32'd1033, 16'd352, 16'd288));
        pending_items.push_back(make_item(OP_READ, 8'(NUM_CH - 1), '0, 1'b0, '0, '0,
                                          '0, '0));
        pending_items.push_back(make_item(OP_UPDATE, 8'd7, 32'hDEAD_BEEF, 1'b1,
                                          32'hFFFF_FFF0, 32'h0000_0010, 16'd8192,
                                          16'd4096));
        pending_items.push_back(make_item(OP_CLEAR_GLOBAL, 8'hFF, '0, 1'b0, '0, '0,
                                          '0, '0));
        pending_items.push_back(make_item(OP_UPDATE, 8'd0, 32'd1, 1'b0, 32'd50, 32'd49,
                                          16'd1, 16'd1));
      end
      // stray-channel updates and reads do not count toward the phase size
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_frame_item();
        pending_items.push_back(it);
        if (!((it.op == OP_UPDATE || it.op == OP_READ) && it.channel >= NUM_CH))
          counted++;
      end
      while (pending_items.size() != 0) @(negedge clk_i);
    end

    // drain: last request accepted and every result back
    while (in_valid || expected_stats.size() != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
